// ----- src/tgarle_pkg.sv -----
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants of the run-length truecolor pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

    localparam int MAX_PACKET_PIXELS = 128;
    localparam int COUNT_W           = $clog2(MAX_PACKET_PIXELS);
    localparam int RUN_FLAG_BIT      = 7;

    localparam int BPP_W       = 3;
    localparam int TOTAL_W     = 32;
    localparam int DECODED_W   = TOTAL_W + 1;
    localparam int PART_W      = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
    localparam logic [BPP_W-1:0]   BPP_MIN     = 3'd2;
    localparam logic [BPP_W-1:0]   BPP_MAX     = 3'd4;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd1;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_BPP   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TOTAL = 2'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        image_done;
        logic        overflow_error;
    } out_item_t;

    typedef struct packed {
        logic [BPP_W-1:0]   bytes_per_pixel;
        logic [TOTAL_W-1:0] total_pixels;
    } cfg_t;

endpackage

// ----- src/tgarle_in_stage.sv -----
// ----------------------------------------------------------------------------
// tgarle_in_stage
// Input register: holds one byte beat until the decode stage consumes it.
// ----------------------------------------------------------------------------
module tgarle_in_stage
    import tgarle_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     consume,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;
    logic     take;

    assign s_ready    = !valid_reg || consume;
    assign take       = s_valid && s_ready;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= s_data;
        end
    end

endmodule

// ----- src/tgarle_decode.sv -----
// ----------------------------------------------------------------------------
// tgarle_decode
// Packet state and pixel assembly; one byte is decoded per consumed beat.
// ----------------------------------------------------------------------------
module tgarle_decode
    import tgarle_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      consume,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output logic      res_valid,
    output out_item_t res
);

    logic                 expecting_header_reg, expecting_header_next;
    logic                 packet_is_run_reg, packet_is_run_next;
    logic [7:0]           pixels_left_reg, pixels_left_next;
    logic [1:0]           byte_position_reg, byte_position_next;
    logic [PART_W-1:0]    partial_pixel_reg, partial_pixel_next;
    logic [DECODED_W-1:0] pixels_decoded_reg, pixels_decoded_next;
    logic                 frame_finished_reg, frame_finished_next;

    // state as seen by this byte, after a possible frame restart
    logic                 cur_header;
    logic                 cur_run;
    logic [7:0]           cur_left;
    logic [1:0]           cur_pos;
    logic [PART_W-1:0]    cur_part;
    logic [DECODED_W-1:0] cur_decoded;
    logic                 cur_finished;

    logic [BPP_W-1:0]     bpp_eff;
    logic                 last_byte;
    logic [7:0]           b;
    logic [31:0]          byte_lane;
    logic [31:0]          pixel;
    logic [7:0]           count;
    logic [DECODED_W-1:0] total_ext;

    assign b         = item.data_byte;
    assign total_ext = {1'b0, cfg.total_pixels};

    always_comb begin
        if (item.frame_start) begin
            cur_header   = 1'b1;
            cur_run      = 1'b0;
            cur_left     = '0;
            cur_pos      = '0;
            cur_part     = '0;
            cur_decoded  = '0;
            cur_finished = 1'b0;
        end else begin
            cur_header   = expecting_header_reg;
            cur_run      = packet_is_run_reg;
            cur_left     = pixels_left_reg;
            cur_pos      = byte_position_reg;
            cur_part     = partial_pixel_reg;
            cur_decoded  = pixels_decoded_reg;
            cur_finished = frame_finished_reg;
        end
    end

    always_comb begin
        if (cfg.bytes_per_pixel < BPP_MIN) begin
            bpp_eff = BPP_MIN;
        end else if (cfg.bytes_per_pixel > BPP_MAX) begin
            bpp_eff = BPP_MAX;
        end else begin
            bpp_eff = cfg.bytes_per_pixel;
        end
    end

    assign last_byte = ({1'b0, cur_pos} + 3'd1) >= bpp_eff;

    always_comb begin
        case (cur_pos)
            2'd0:    byte_lane = {24'b0, b};
            2'd1:    byte_lane = {16'b0, b, 8'b0};
            2'd2:    byte_lane = {8'b0, b, 16'b0};
            default: byte_lane = {b, 24'b0};
        endcase
    end

    assign pixel = {8'b0, cur_part} | byte_lane;
    assign count = cur_run ? cur_left : 8'd1;

    always_comb begin
        expecting_header_next = cur_header;
        packet_is_run_next    = cur_run;
        pixels_left_next      = cur_left;
        byte_position_next    = cur_pos;
        partial_pixel_next    = cur_part;
        pixels_decoded_next   = cur_decoded;
        frame_finished_next   = cur_finished;
        res_valid             = 1'b0;
        res.pixel_value       = pixel;
        res.repeat_count      = count;
        res.image_done        = 1'b0;
        res.overflow_error    = 1'b0;
        if (!cur_finished) begin
            if (cur_header) begin
                packet_is_run_next    = b[RUN_FLAG_BIT];
                pixels_left_next      = {1'b0, b[COUNT_W-1:0]} + 8'd1;
                byte_position_next    = '0;
                partial_pixel_next    = '0;
                expecting_header_next = 1'b0;
            end else if (!last_byte) begin
                partial_pixel_next = cur_part | byte_lane[PART_W-1:0];
                byte_position_next = cur_pos + 2'd1;
            end else begin
                partial_pixel_next  = '0;
                byte_position_next  = '0;
                pixels_left_next    = cur_run ? 8'd0 : cur_left - 8'd1;
                pixels_decoded_next = cur_decoded + {{(DECODED_W-8){1'b0}}, count};
                res_valid           = 1'b1;
                res.image_done      = pixels_decoded_next >= total_ext;
                res.overflow_error  = pixels_decoded_next > total_ext;
                if (pixels_left_next == 8'd0) begin
                    expecting_header_next = 1'b1;
                    frame_finished_next   = res.image_done;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expecting_header_reg <= 1'b1;
            packet_is_run_reg    <= 1'b0;
            pixels_left_reg      <= '0;
            byte_position_reg    <= '0;
            partial_pixel_reg    <= '0;
            pixels_decoded_reg   <= '0;
            frame_finished_reg   <= 1'b0;
        end else if (consume) begin
            expecting_header_reg <= expecting_header_next;
            packet_is_run_reg    <= packet_is_run_next;
            pixels_left_reg      <= pixels_left_next;
            byte_position_reg    <= byte_position_next;
            partial_pixel_reg    <= partial_pixel_next;
            pixels_decoded_reg   <= pixels_decoded_next;
            frame_finished_reg   <= frame_finished_next;
        end
    end

    // nothing is collected before the first byte of a pixel
    a_part_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_position_reg == 2'd0 |-> partial_pixel_reg == '0)
        else $error("partial pixel not empty at byte position zero");

    // inside a packet there is always at least one pixel still to come
    a_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        !expecting_header_reg && !frame_finished_reg |-> pixels_left_reg != 8'd0)
        else $error("packet active with no pixels left");

    // a finished frame ignores bytes until a restart
    a_finished_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && frame_finished_reg && !item.frame_start
        |=> $stable(pixels_decoded_reg) && frame_finished_reg)
        else $error("state changed after frame end");

    // header bytes never produce a result
    a_header_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_header |-> !res_valid)
        else $error("result from a header byte");

    a_ovf_implies_done: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.overflow_error |-> res.image_done)
        else $error("overflow without image done");

endmodule

// ----- src/tgarle_out_stage.sv -----
// ----------------------------------------------------------------------------
// tgarle_out_stage
// Result register: holds one decoded beat until the sink takes it.
// ----------------------------------------------------------------------------
module tgarle_out_stage
    import tgarle_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    output logic      room,
    input  logic      load,
    input  out_item_t res,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign room    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

endmodule

// ----- src/tga_rle_packet_decoder.sv -----
// ----------------------------------------------------------------------------
// tga_rle_packet_decoder
// Run-length truecolor pixel stream decoder, one compressed byte per beat.
//
//   channel | ports                      | payload
//   --------+----------------------------+-------------------------------
//   input   | s_valid s_ready s_data     | data_byte, frame_start
//   result  | m_valid m_ready m_data     | pixel, repeat, done, overflow
//   config  | cfg_we cfg_index cfg_wdata | bytes_per_pixel, total_pixels
//
// One byte per cycle sustained while the result side does not stall.
// The input register feeds the decode logic, which writes the result register.
// Header bytes and non-final pixel bytes give no result beat.
// A stalled result holds the decode stage; the input register still takes a beat while empty.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module tga_rle_packet_decoder
    import tgarle_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             item_valid;
    in_item_t         item;
    logic             room;
    logic             consume;
    logic             res_valid;
    out_item_t        res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_IDX_BPP:   cfg_next.bytes_per_pixel = cfg_wdata[BPP_W-1:0];
                CFG_IDX_TOTAL: cfg_next.total_pixels    = cfg_wdata[TOTAL_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bytes_per_pixel <= BPP_RESET;
            cfg_reg.total_pixels    <= TOTAL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign consume = item_valid && room;

    tgarle_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    tgarle_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .consume   (consume),
        .item      (item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    tgarle_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .room    (room),
        .load    (consume && res_valid),
        .res     (res),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives run-length packet streams into tga_rle_packet_decoder one byte per
// beat and checks every result beat against a cycle-free model of the decoder
// held in a small checker class. Covers all pixel sizes (also out-of-range
// settings), run and raw packets up to 128 pixels, frame completion, overflow,
// ignored bytes and frame restarts, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench
    import tgarle_pkg::*;
();

    localparam int ITEM_TARGET    = 950;
    localparam int MAX_GAP        = 6;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    // index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE = 2'd2;

    // frame start on a header, a finished frame, restarts and a restart mid-packet
    localparam logic [8:0] DIRECTED [22] = '{
        {8'h80, 1'b1}, {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b0},
        {8'hff, 1'b0},
        {8'hff, 1'b1}, {8'hff, 1'b0}, {8'hff, 1'b0}, {8'hff, 1'b0},
        {8'h01, 1'b1}, {8'h11, 1'b0}, {8'h22, 1'b0}, {8'h33, 1'b0},
        {8'h44, 1'b0}, {8'h55, 1'b0}, {8'h66, 1'b0},
        {8'h00, 1'b0},
        {8'h00, 1'b1}, {8'h80, 1'b1}, {8'haa, 1'b0}, {8'hbb, 1'b0}, {8'hcc, 1'b0}
    };

    class rle_checker;
        logic [BPP_W-1:0]     bpp_reg;
        logic [TOTAL_W-1:0]   total_reg;
        bit                   want_header;
        bit                   run_packet;
        logic [7:0]           pixels_left;
        logic [1:0]           byte_pos;
        logic [PART_W-1:0]    partial;
        logic [DECODED_W-1:0] decoded;
        bit                   finished;
        out_item_t            expected_pixels[$];
        int                   mismatches;
        int                   result_beats;
        int                   done_beats;
        int                   overflow_beats;

        function new();
            bpp_reg        = BPP_RESET;
            total_reg      = TOTAL_RESET;
            mismatches     = 0;
            result_beats   = 0;
            done_beats     = 0;
            overflow_beats = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            want_header = 1'b1;
            run_packet  = 1'b0;
            pixels_left = '0;
            byte_pos    = '0;
            partial     = '0;
            decoded     = '0;
            finished    = 1'b0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_IDX_BPP) begin
                bpp_reg = val[BPP_W-1:0];
            end else if (idx == CFG_IDX_TOTAL) begin
                total_reg = val[TOTAL_W-1:0];
            end
        endfunction

        function int pixel_size();
            if (bpp_reg < BPP_MIN) return int'(BPP_MIN);
            if (bpp_reg > BPP_MAX) return int'(BPP_MAX);
            return int'(bpp_reg);
        endfunction

        // returns 0 when the byte is dropped because the frame is over
        function bit take_byte(in_item_t beat);
            out_item_t r;
            if (beat.frame_start) restart_frame();
            if (finished) return 1'b0;
            if (want_header) begin
                run_packet  = beat.data_byte[RUN_FLAG_BIT];
                pixels_left = {1'b0, beat.data_byte[COUNT_W-1:0]} + 8'd1;
                byte_pos    = '0;
                partial     = '0;
                want_header = 1'b0;
                return 1'b1;
            end
            if (int'(byte_pos) + 1 < pixel_size()) begin
                partial  = partial | (PART_W'(beat.data_byte) << (8 * byte_pos));
                byte_pos = byte_pos + 2'd1;
                return 1'b1;
            end
            r.pixel_value = 32'(partial) | (32'(beat.data_byte) << (8 * byte_pos));
            partial  = '0;
            byte_pos = '0;
            if (run_packet) begin
                r.repeat_count = pixels_left;
                pixels_left    = '0;
            end else begin
                r.repeat_count = 8'd1;
                pixels_left    = pixels_left - 8'd1;
            end
            decoded          = decoded + DECODED_W'(r.repeat_count);
            r.image_done     = (decoded >= DECODED_W'(total_reg));
            r.overflow_error = (decoded > DECODED_W'(total_reg));
            if (pixels_left == 0) begin
                want_header = 1'b1;
                if (r.image_done) finished = 1'b1;
            end
            expected_pixels.push_back(r);
            return 1'b1;
        endfunction

        function void report(string what, logic [31:0] want_v, logic [31:0] got_v);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch at %0t on %s: expected %h, got %h", $time, what, want_v, got_v);
            end
        endfunction

        function void check_pixel(out_item_t got);
            out_item_t want;
            result_beats++;
            if (got.image_done === 1'b1) done_beats++;
            if (got.overflow_error === 1'b1) overflow_beats++;
            if (expected_pixels.size() == 0) begin
                report("unexpected result beat, pixel_value", 'x, got.pixel_value);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_value !== want.pixel_value)
                report("pixel_value", want.pixel_value, got.pixel_value);
            if (got.repeat_count !== want.repeat_count)
                report("repeat_count", 32'(want.repeat_count), 32'(got.repeat_count));
            if (got.image_done !== want.image_done)
                report("image_done", 32'(want.image_done), 32'(got.image_done));
            if (got.overflow_error !== want.overflow_error)
                report("overflow_error", 32'(want.overflow_error), 32'(got.overflow_error));
        endfunction

        function void flush_check();
            out_item_t want;
            while (expected_pixels.size() != 0) begin
                want = expected_pixels.pop_front();
                report("missing result beat, pixel_value", want.pixel_value, 'x);
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    rle_checker sb = new();
    bit         tx_burst;
    bit         rx_burst;
    bit         hold_req;
    int         bytes_used;
    int         bytes_ignored;
    int         settings;

    tga_rle_packet_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // one input beat; valid stays up on return so back-to-back beats need no toggle
    task automatic drive_beat(in_item_t item);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        if (sb.take_byte(item)) bytes_used++;
        else bytes_ignored++;
    endtask

    // occasional stray frame start breaks the packet structure
    task automatic put_byte(logic [7:0] value, bit fs);
        in_item_t item;
        item.data_byte   = value;
        item.frame_start = fs | ($urandom_range(0, 79) == 0);
        drive_beat(item);
    endtask

    task automatic send_packet(bit fs);
        bit run;
        int cnt;
        run = 1'($urandom_range(0, 1));
        if (run)
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
        else
            cnt = ($urandom_range(0, 59) == 0) ? $urandom_range(60, 128) : $urandom_range(1, 6);
        put_byte({run, 7'(cnt - 1)}, fs);
        repeat (run ? 1 : cnt) begin
            repeat (sb.pixel_size()) put_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic send_frame();
        int npk;
        npk = $urandom_range(1, 6);
        for (int p = 0; p < npk; p++) send_packet(p == 0);
        // trailing bytes land after the frame has finished when the total is small
        repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(logic [BPP_W-1:0] bpp, logic [TOTAL_W-1:0] total, bit spare);
        logic [CFG_DATA_W-1:0] w;
        w = $urandom;
        w[BPP_W-1:0] = bpp;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_BPP;
        cfg_wdata <= w;
        @(posedge aclk);
        sb.write_reg(CFG_IDX_BPP, w);
        cfg_index <= CFG_IDX_TOTAL;
        cfg_wdata <= total;
        @(posedge aclk);
        sb.write_reg(CFG_IDX_TOTAL, total);
        if (spare) begin
            w = $urandom;
            cfg_index <= CFG_IDX_SPARE;
            cfg_wdata <= w;
            @(posedge aclk);
            sb.write_reg(CFG_IDX_SPARE, w);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    // result side: random stalls, bursts, and one long hold on request
    initial begin : result_sink
        int gap;
        int beats;
        beats = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end
            if (beats % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_pixel(m_data);
            beats++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [BPP_W-1:0]   bpp;
        logic [TOTAL_W-1:0] total;
        int                 phase;
        bytes_used    = 0;
        bytes_ignored = 0;
        settings      = 0;
        tx_burst      = 1'b0;
        hold_req      = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: 24-bit pixels, total of one
        foreach (DIRECTED[i]) drive_beat(in_item_t'(DIRECTED[i]));
        drain_pipeline();

        for (phase = 0; bytes_used + bytes_ignored < ITEM_TARGET; phase++) begin
            case (phase)
                0: bpp = 3'd2;
                1: bpp = 3'd4;
                2: bpp = 3'd0;
                3: bpp = 3'd7;
                4: bpp = 3'd1;
                5: bpp = 3'd5;
                6: bpp = 3'd6;
                7: bpp = 3'd3;
                default: bpp = 3'($urandom_range(0, 7));
            endcase
            if (phase == 0) total = '0;
            else if (phase == 1) total = '1;
            else if ($urandom_range(0, 7) == 0) total = $urandom;
            else total = $urandom_range(1, 24);
            write_config(bpp, total, $urandom_range(0, 2) == 0);
            tx_burst = ($urandom_range(0, 3) == 0);
            // input keeps coming while the result side stalls
            if (phase == 3) begin
                tx_burst = 1'b1;
                hold_req = 1'b1;
            end
            repeat ($urandom_range(1, 3)) send_frame();
            drain_pipeline();
        end

        sb.flush_check();
        $display("covered %0d decoded and %0d ignored input beats over %0d register settings",
                 bytes_used, bytes_ignored, settings);
        $display("checked %0d result beats, %0d completing a frame, %0d overflowing",
                 sb.result_beats, sb.done_beats, sb.overflow_beats);
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches in total", sb.mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
